@@ rtl/core/aes_pkg.sv @@
// Shared types and constants for the escape-sequence stripper.
// Used by aes_core, aes_fifo and ansi_escape_stripper_top; depends on nothing.
package aes_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int KC_W        = COUNT_WIDTH + 1;
  localparam int MAX_RES     = 5;
  localparam int NRES_W      = $clog2(MAX_RES + 1);
  localparam int FIFO_DEPTH  = 8;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [15:0] BYTE_LIMIT_RESET = 16'd256;

  localparam logic [7:0] CH_BEL   = 8'h07;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_FIN_LO = 8'h40;
  localparam logic [7:0] CH_LBRACK = 8'h5b;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_RBRACK = 8'h5d;
  localparam logic [7:0] CH_FIN_HI = 8'h7e;
  localparam logic [7:0] CH_DEL   = 8'h7f;

  typedef enum logic [4:0] {
    MODE_NORMAL  = 5'b00001,
    MODE_ESC     = 5'b00010,
    MODE_CSI     = 5'b00100,
    MODE_OSC     = 5'b01000,
    MODE_OSC_ESC = 5'b10000
  } mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [NRES_W-1:0]      count;
    res_t [MAX_RES-1:0]     slot;
  } batch_t;

endpackage

@@ rtl/core/aes_core.sv @@
// Parser, whitespace folding, length limit and tail hold of the stripper.
// Turns one registered input item into a batch of results; depends on aes_pkg.
module aes_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [15:0]          cfg_data,
  input  logic [7:0]           item_byte,
  input  logic                 item_has,
  input  logic                 item_last,
  input  logic                 take,
  output aes_pkg::batch_t      batch
);
  import aes_pkg::*;

  typedef struct packed {
    logic            emit;
    logic            hold;
    logic [KC_W-1:0] kc;
    logic [1:0]      tc;
  } keep_t;

  localparam logic [KC_W-1:0] KC_MAX = {KC_W{1'b1}};

  logic [15:0]            byte_limit;
  mode_t                  mode, mode_next;
  logic                   space_pending, space_pending_next;
  logic [KC_W-1:0]        kept_count, kept_count_next;
  logic [1:0]             tail_count, tail_count_next;
  logic [7:0]             tail_hold [3];
  logic [7:0]             hold_next [3];
  logic [COUNT_WIDTH-1:0] lim;
  logic [COUNT_WIDTH-1:0] start;
  logic                   norm, keep_a, keep_b, is_ws, is_text, over;
  keep_t                  ka, kb;
  logic [KC_W-1:0]        kc1, kc2;
  logic [1:0]             tc1, tc2;
  logic [NRES_W-1:0]      n;

  function automatic keep_t do_keep(input logic [KC_W-1:0] kc, input logic [1:0] tc,
                                    input logic [COUNT_WIDTH-1:0] lm,
                                    input logic [COUNT_WIDTH-1:0] st);
    keep_t r;
    r.emit = kc < {1'b0, st};
    r.hold = !r.emit && (kc < {1'b0, lm}) && (tc != 2'd3);
    r.kc   = (kc == KC_MAX) ? kc : kc + 1'b1;
    r.tc   = r.hold ? tc + 2'd1 : tc;
    return r;
  endfunction

  assign lim   = COUNT_WIDTH'(byte_limit);
  assign start = (lim > COUNT_WIDTH'(3)) ? lim - COUNT_WIDTH'(3) : '0;
  assign is_ws = (item_byte == CH_SPACE) || ((item_byte >= CH_TAB) && (item_byte <= CH_CR));
  assign is_text = (item_byte > CH_SPACE) && (item_byte != CH_DEL);

  always_comb begin
    mode_next = mode;
    norm      = 1'b0;
    if (item_has) begin
      unique case (mode)
        MODE_NORMAL: norm = 1'b1;
        MODE_ESC: begin
          if (item_byte == CH_LBRACK) begin
            mode_next = MODE_CSI;
          end else if (item_byte == CH_RBRACK) begin
            mode_next = MODE_OSC;
          end else begin
            mode_next = MODE_NORMAL;
            norm      = 1'b1;
          end
        end
        MODE_CSI: begin
          if ((item_byte >= CH_FIN_LO) && (item_byte <= CH_FIN_HI)) begin
            mode_next = MODE_NORMAL;
          end
        end
        MODE_OSC: begin
          if (item_byte == CH_BEL) begin
            mode_next = MODE_NORMAL;
          end else if (item_byte == CH_ESC) begin
            mode_next = MODE_OSC_ESC;
          end
        end
        MODE_OSC_ESC: begin
          if ((item_byte == CH_BSLASH) || (item_byte == CH_BEL)) begin
            mode_next = MODE_NORMAL;
          end else if (item_byte != CH_ESC) begin
            mode_next = MODE_OSC;
          end
        end
        default: begin
          mode_next = MODE_NORMAL;
          norm      = 1'b1;
        end
      endcase
    end

    space_pending_next = space_pending;
    keep_a = 1'b0;
    keep_b = 1'b0;
    if (norm) begin
      if (item_byte == CH_ESC) begin
        mode_next = MODE_ESC;
      end else if (is_ws) begin
        space_pending_next = (kept_count != '0);
      end else if (is_text) begin
        keep_a = space_pending;
        keep_b = 1'b1;
        space_pending_next = 1'b0;
      end
    end
  end

  always_comb begin
    ka  = do_keep(kept_count, tail_count, lim, start);
    kc1 = keep_a ? ka.kc : kept_count;
    tc1 = keep_a ? ka.tc : tail_count;
    kb  = do_keep(kc1, tc1, lim, start);
    kc2 = keep_b ? kb.kc : kc1;
    tc2 = keep_b ? kb.tc : tc1;

    hold_next = tail_hold;
    if (keep_a && ka.hold) begin
      hold_next[tail_count] = CH_SPACE;
    end
    if (keep_b && kb.hold) begin
      hold_next[tc1] = item_byte;
    end

    over = kc2 > KC_W'(lim);
    n = '0;
    batch.slot = '0;
    if (keep_a && ka.emit) begin
      batch.slot[n] = '{data: CH_SPACE, valid: 1'b1, last: 1'b0};
      n = n + 1'b1;
    end
    if (keep_b && kb.emit) begin
      batch.slot[n] = '{data: item_byte, valid: 1'b1, last: 1'b0};
      n = n + 1'b1;
    end
    if (item_last) begin
      for (int i = 0; i < 3; i++) begin
        if (2'(i) < tc2) begin
          batch.slot[n] = '{data: over ? CH_DOT : hold_next[i], valid: 1'b1, last: 1'b0};
          n = n + 1'b1;
        end
      end
      if (n != '0) begin
        batch.slot[n - 1'b1].last = 1'b1;
      end else begin
        batch.slot[0] = '{data: 8'h00, valid: 1'b0, last: 1'b1};
        n = NRES_W'(1);
      end
    end
    batch.count = n;

    kept_count_next = item_last ? '0 : kc2;
    tail_count_next = item_last ? 2'd0 : tc2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_limit    <= BYTE_LIMIT_RESET;
      mode          <= MODE_NORMAL;
      space_pending <= 1'b0;
      kept_count    <= '0;
      tail_count    <= 2'd0;
    end else begin
      if (cfg_we) begin
        byte_limit <= cfg_data;
      end
      if (take) begin
        mode          <= item_last ? MODE_NORMAL : mode_next;
        space_pending <= item_last ? 1'b0 : space_pending_next;
        kept_count    <= kept_count_next;
        tail_count    <= tail_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      tail_hold <= hold_next;
    end
  end

`ifndef ASSERT_OFF
  a_mode_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(mode))
    else $error("parser mode is not one-hot");
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
                                  take && item_last |=> kept_count == '0 && tail_count == 2'd0)
    else $error("text state not cleared after end of text");
  a_hold_below_limit: assert property (@(posedge clk) disable iff (rst)
                                       tail_count != 2'd0 |-> kept_count != '0)
    else $error("held bytes without kept bytes");
`endif

endmodule

@@ rtl/core/aes_fifo.sv @@
// Result queue of the stripper: takes a batch of up to five results per cycle
// and hands out one per transfer. Depends on aes_pkg.
module aes_fifo (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  aes_pkg::batch_t              batch,
  output logic [aes_pkg::FCNT_W-1:0]   space,
  output logic                         res_valid,
  input  logic                         res_ready,
  output aes_pkg::res_t                res
);
  import aes_pkg::*;

  res_t              mem [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr, rd_ptr;
  logic [FCNT_W-1:0] count, count_next;
  logic              pop;
  logic [FCNT_W-1:0] add;

  assign space     = FCNT_W'(FIFO_DEPTH) - count;
  assign res_valid = count != '0;
  assign res       = mem[rd_ptr];
  assign pop       = res_valid && res_ready;
  assign add       = push ? FCNT_W'(batch.count) : '0;
  assign count_next = count + add - FCNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(add);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RES; k++) begin
      if (push && (NRES_W'(k) < batch.count)) begin
        mem[wr_ptr + PTR_W'(k)] <= batch.slot[k];
      end
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
                                  push |-> FCNT_W'(batch.count) <= space)
    else $error("result queue overflow");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
                                  count <= FCNT_W'(FIFO_DEPTH))
    else $error("result queue count out of range");
`endif

endmodule

@@ rtl/core/ansi_escape_stripper_top.sv @@
// Top level of the escape-sequence stripper: input register, core and result queue.
// Depends on aes_pkg, aes_core and aes_fifo.
//
// Usage: text bytes enter on the input channel (in_valid/in_ready) with data_byte,
// has_byte and is_last; an item with has_byte low and is_last high only ends the text.
// Results leave on the result channel (res_valid/res_ready) as out_byte, out_valid and
// out_last; out_last marks the final result of a text, and an end of text with nothing
// to show yields one result with out_valid low. The output byte limit is written
// through cfg_we/cfg_data while the block is idle.
// An item's results pass through the input register and then the result queue before they are offered.
// Throughput: one input transfer per cycle while the eight-entry result queue has room
// for the item's results; the result channel moves one result per cycle while res_ready
// is high, and an item yields up to two results mid-text and up to five at the end.
// Reset clears the parser, counters and queue and sets the byte limit to 256. When the
// receiver stalls, results wait in the queue and input is taken until it fills.
module ansi_escape_stripper_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        is_last,
  output logic        res_valid,
  input  logic        res_ready,
  output logic [7:0]  out_byte,
  output logic        out_valid,
  output logic        out_last
);
  import aes_pkg::*;

  logic              inq_valid;
  logic [7:0]        inq_byte;
  logic              inq_has;
  logic              inq_last;
  logic              push;
  batch_t            batch;
  logic [FCNT_W-1:0] space;
  res_t              res;

  assign push     = inq_valid && (FCNT_W'(batch.count) <= space);
  assign in_ready = !inq_valid || push;

  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      inq_byte <= data_byte;
      inq_has  <= has_byte;
      inq_last <= is_last;
    end
  end

  aes_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .item_byte (inq_byte),
    .item_has  (inq_has),
    .item_last (inq_last),
    .take      (push),
    .batch     (batch)
  );

  aes_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .batch     (batch),
    .space     (space),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign out_byte  = res.data;
  assign out_valid = res.valid;
  assign out_last  = res.last;

endmodule
